// File: sv/swmm_pkg.sv
package swmm_pkg;

    // Storage and field widths
    localparam int WINDOW_MAX    = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int ADDR_BITS     = $clog2(WINDOW_MAX);
    localparam int LEN_BITS      = 7;
    localparam int SUM_BITS      = SAMPLE_BITS + ADDR_BITS;
    localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic [LEN_BITS-1:0]           len_t;
    typedef logic [ADDR_BITS-1:0]          addr_t;

    // Register map (word index within the APB space)
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    localparam len_t LEN_RESET = len_t'(8);
    localparam len_t LEN_LIMIT = len_t'(WINDOW_MAX);
    localparam len_t LEN_MIN   = len_t'(2);

    // Scan start values
    localparam sample_t SAMPLE_POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_NEG_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Status codes
    localparam logic STATUS_VALID = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    // Handshake between sequencer and divider
    typedef struct packed {
        logic start;
        len_t divisor;
    } div_req_t;

endpackage

// File: sv/sliding_window_min_avg_max.sv
// With L the effective window length (2..64), each accepted item is scanned by L
// RAM reads through the shared compare/add unit; once the reads drain, the serial
// divider runs 22 steps. A window of one or zero skips the scan and the divider.
// A new item is not accepted until the previous result has entered the output register.
// Reset clears the sequencer, write pointer, fill count and sets window_length
// to 8; the first sample after reset stands in for every ring entry not yet written.
module sliding_window_min_avg_max (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,
    // window_min [15:0], window_mean [31:16], window_max [47:32]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [47:0]                         m_axis_tdata,
    // status [0]
    output logic [0:0]                          m_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swmm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [swmm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [swmm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import swmm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic          primed_reg, primed_next;
    len_t          fill_reg, fill_next;
    addr_t         wptr_reg, wptr_next;
    sample_t       prime_reg, prime_next;
    len_t          cfg_len_reg, cfg_len_next;
    len_t          len_reg, len_next;
    len_t          remain_reg, remain_next;
    addr_t         rd_addr_reg, rd_addr_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          rd_prime_reg, rd_prime_next;
    sample_t       min_reg, min_next;
    sample_t       max_reg, max_next;
    sum_t          sum_reg, sum_next;
    logic          short_reg, short_next;
    logic          out_valid_reg, out_valid_next;
    sample_t       out_min_reg, out_min_next;
    sample_t       out_mean_reg, out_mean_next;
    sample_t       out_max_reg, out_max_next;
    logic          out_status_reg, out_status_next;

    logic          in_fire;
    logic          cfg_write;
    logic          ram_re;
    sample_t       ram_rdata;
    sample_t       scan_val;
    div_req_t      div_req;
    logic          div_done;
    sample_t       div_quo;
    len_t          len_eff;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign ram_re    = (state_reg == ST_SCAN) && (remain_reg != '0);
    assign scan_val  = rd_prime_reg ? prime_reg : ram_rdata;
    assign len_eff   = (cfg_len_reg > LEN_LIMIT) ? LEN_LIMIT : cfg_len_reg;

    // Ring of recent samples
    swmm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (in_fire),
        .waddr (wptr_reg),
        .wdata (s_axis_tdata),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Serial divider for the mean
    swmm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (sum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        primed_next     = primed_reg;
        fill_next       = fill_reg;
        wptr_next       = wptr_reg;
        prime_next      = prime_reg;
        cfg_len_next    = cfg_len_reg;
        len_next        = len_reg;
        remain_next     = remain_reg;
        rd_addr_next    = rd_addr_reg;
        rd_pend_next    = 1'b0;
        rd_prime_next   = rd_prime_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        sum_next        = sum_reg;
        short_next      = short_reg;
        out_valid_next  = out_valid_reg;
        out_min_next    = out_min_reg;
        out_mean_next   = out_mean_reg;
        out_max_next    = out_max_reg;
        out_status_next = out_status_reg;
        div_req.start   = 1'b0;
        div_req.divisor = len_reg;

        if (cfg_write && (paddr[2] == REG_WINDOW_LENGTH))
        begin
            cfg_len_next = pwdata[LEN_BITS-1:0];
        end

        // Drop the result once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!primed_reg)
                    begin
                        prime_next  = s_axis_tdata;
                        primed_next = 1'b1;
                        fill_next   = len_t'(1);
                    end
                    else if (fill_reg != LEN_LIMIT)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    wptr_next    = wptr_reg + 1'b1;
                    rd_addr_next = wptr_reg;
                    len_next     = len_eff;
                    remain_next  = len_eff;
                    min_next     = SAMPLE_POS_MAX;
                    max_next     = SAMPLE_NEG_MAX;
                    sum_next     = '0;
                    short_next   = (cfg_len_reg < LEN_MIN);
                    state_next   = (cfg_len_reg < LEN_MIN) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Issue one read a cycle, walking back from the newest slot
                if (remain_reg != '0)
                begin
                    rd_pend_next  = 1'b1;
                    rd_prime_next = ({1'b0, rd_addr_reg} >= fill_reg);
                    rd_addr_next  = rd_addr_reg - 1'b1;
                    remain_next   = remain_reg - 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_min_next    = short_reg ? '0 : min_reg;
                    out_mean_next   = short_reg ? '0 : div_quo;
                    out_max_next    = short_reg ? '0 : max_reg;
                    out_status_next = short_reg ? STATUS_SHORT : STATUS_VALID;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Shared compare/add unit on the returning read
        if (rd_pend_reg)
        begin
            if (scan_val < min_reg)
            begin
                min_next = scan_val;
            end
            if (scan_val > max_reg)
            begin
                max_next = scan_val;
            end
            sum_next = sum_reg + sum_t'(scan_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            primed_reg    <= 1'b0;
            fill_reg      <= '0;
            wptr_reg      <= '0;
            cfg_len_reg   <= LEN_RESET;
            remain_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            primed_reg    <= primed_next;
            fill_reg      <= fill_next;
            wptr_reg      <= wptr_next;
            cfg_len_reg   <= cfg_len_next;
            remain_reg    <= remain_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_reg      <= prime_next;
        len_reg        <= len_next;
        rd_addr_reg    <= rd_addr_next;
        rd_prime_reg   <= rd_prime_next;
        min_reg        <= min_next;
        max_reg        <= max_next;
        sum_reg        <= sum_next;
        short_reg      <= short_next;
        out_min_reg    <= out_min_next;
        out_mean_reg   <= out_mean_next;
        out_max_reg    <= out_max_next;
        out_status_reg <= out_status_next;
    end

    // Ports
    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {out_max_reg, out_mean_reg, out_min_reg};
    assign m_axis_tuser[0] = out_status_reg;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == REG_WINDOW_LENGTH)
                             ? {{(APB_DATA_BITS-LEN_BITS){1'b0}}, cfg_len_reg}
                             : '0;

    // Checks
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[0] == STATUS_SHORT)) |-> (m_axis_tdata == '0))
        else $error("short window result carries nonzero statistics");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[0] == STATUS_VALID)) |->
        (($signed(out_min_reg) <= $signed(out_mean_reg)) &&
         ($signed(out_mean_reg) <= $signed(out_max_reg))))
        else $error("mean outside min..max");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == ST_SCAN))
        else $error("ring read returned outside the scan");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= LEN_LIMIT) && (primed_reg == (fill_reg != '0)))
        else $error("fill count out of step with priming");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> (state_reg == ST_DIV))
        else $error("divider started outside the scan end");

endmodule

// File: sv/swmm_ram.sv
module swmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/swmm_div.sv
module swmm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  swmm_pkg::div_req_t req,
    input  swmm_pkg::sum_t    dividend,
    output logic              done,
    output swmm_pkg::sample_t quotient
);
    import swmm_pkg::*;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_FIX
    } dv_state_t;

    dv_state_t               state_reg, state_next;
    logic [SUM_BITS-1:0]     quo_reg, quo_next;
    logic [LEN_BITS-1:0]     rem_reg, rem_next;
    len_t                    dvs_reg, dvs_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    neg_reg, neg_next;
    logic                    done_reg, done_next;
    sample_t                 res_reg, res_next;

    logic [LEN_BITS:0]       trial;
    logic [LEN_BITS:0]       diff;
    logic                    fits;
    logic [SUM_BITS-1:0]     signed_quo;

    // One restoring step a cycle on the magnitude
    assign trial      = {rem_reg, quo_reg[SUM_BITS-1]};
    assign diff       = trial - {1'b0, dvs_reg};
    assign fits       = (trial >= {1'b0, dvs_reg});
    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    always_comb
    begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (req.start)
                begin
                    neg_next   = dividend[SUM_BITS-1];
                    quo_next   = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
                    rem_next   = '0;
                    dvs_next   = req.divisor;
                    cnt_next   = '0;
                    state_next = DV_RUN;
                end
            end
            DV_RUN:
            begin
                rem_next = fits ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
                quo_next = {quo_reg[SUM_BITS-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(SUM_BITS - 1))
                begin
                    state_next = DV_FIX;
                end
            end
            DV_FIX:
            begin
                // Restore the sign, truncation toward zero falls out
                res_next   = sample_t'(signed_quo[SAMPLE_BITS-1:0]);
                done_next  = 1'b1;
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done     = done_reg;
    assign quotient = res_reg;

endmodule

// File: test/tb_top.sv
module tb_top;
    import swmm_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 11;
    localparam int IDLE_PERCENT = 31;
    // Long enough to cover the worst-case window
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 600;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 630;

    typedef struct {
        sample_t window_min;
        sample_t window_mean;
        sample_t window_max;
        logic    status;
    } window_stats_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [15:0]              s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [47:0]              m_axis_tdata;
    logic [0:0]               m_axis_tuser;
    logic                     psel          = 1'b0;
    logic                     penable       = 1'b0;
    logic                     pwrite        = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr         = '0;
    logic [APB_DATA_BITS-1:0] pwdata        = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Predictor state: sample ring, write slot, fill flag, current length
    sample_t window_ring [WINDOW_MAX];
    addr_t   ring_head         = '0;
    bit      ring_filled       = 1'b0;
    len_t    window_length_cfg = LEN_RESET;

    sample_t       pending_samples [$];
    window_stats_t expected_stats  [$];
    bit            offer_held   = 1'b0;
    bit            steady_flow  = 1'b0;
    bit            hold_request = 1'b0;
    int            hold_left    = 0;
    int            stall_cycles = 0;
    int            error_count  = 0;
    int            windows_checked = 0;
    int            short_windows   = 0;
    int            lengths_written = 0;
    int            random_items    = 0;

    sliding_window_min_avg_max uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // Store the sample and work out min, mean and max of the last L samples
    task automatic predict_window(input sample_t value);
        window_stats_t result;
        int            eff_len;
        int            slot;
        int            k;
        longint        total;
        sample_t       lo;
        sample_t       hi;
        if (!ring_filled)
        begin
            foreach (window_ring[i])
                window_ring[i] = value;
            ring_filled = 1'b1;
        end
        else
            window_ring[ring_head] = value;
        slot = int'(ring_head);
        ring_head = ring_head + 1'b1;
        eff_len = (window_length_cfg > LEN_LIMIT) ? WINDOW_MAX : int'(window_length_cfg);
        if (eff_len < 2)
        begin
            result.window_min  = '0;
            result.window_mean = '0;
            result.window_max  = '0;
            result.status      = STATUS_SHORT;
        end
        else
        begin
            lo    = SAMPLE_POS_MAX;
            hi    = SAMPLE_NEG_MAX;
            total = 0;
            for (k = 0; k < eff_len; k++)
            begin
                if (window_ring[slot] < lo)
                    lo = window_ring[slot];
                if (window_ring[slot] > hi)
                    hi = window_ring[slot];
                total += longint'(window_ring[slot]);
                slot = (slot == 0) ? WINDOW_MAX - 1 : slot - 1;
            end
            result.window_min  = lo;
            result.window_mean = sample_t'(total / longint'(eff_len));
            result.window_max  = hi;
            result.status      = STATUS_VALID;
        end
        expected_stats.push_back(result);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Compare one result item with the oldest expectation
    task automatic check_result();
        window_stats_t want;
        if (expected_stats.size() == 0)
        begin
            error_count++;
            $display("%0t: unexpected result: expected none, actual data %h status %b",
                     $time, m_axis_tdata, m_axis_tuser);
        end
        else
        begin
            want = expected_stats.pop_front();
            windows_checked++;
            if (want.status == STATUS_SHORT)
                short_windows++;
            check_field("window_min", want.window_min, m_axis_tdata[15:0]);
            check_field("window_mean", want.window_mean, m_axis_tdata[31:16]);
            check_field("window_max", want.window_max, m_axis_tdata[47:32]);
            check_field("status", 16'(want.status), 16'(m_axis_tuser[0]));
        end
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(9))
            0: return SAMPLE_POS_MAX;
            1: return SAMPLE_NEG_MAX;
            2: return sample_t'($urandom_range(16) - 8);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Wait until every item is through and the block has gone quiet
    task automatic wait_drained();
        while (pending_samples.size() != 0 || offer_held || expected_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the window length once idle, then read it back
    task automatic reconfigure_window(input len_t value);
        logic [APB_DATA_BITS-1:0] word;
        wait_drained();
        word = $urandom;
        word[LEN_BITS-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'(4 * REG_WINDOW_LENGTH);
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        window_length_cfg = value;
        lengths_written++;
        // Turn straight into the read setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[LEN_BITS-1:0] !== value)
        begin
            error_count++;
            $display("%0t: window_length readback mismatch: expected %h, actual %h",
                     $time, value, prdata[LEN_BITS-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        repeat (count) pending_samples.push_back(rand_sample());
        random_items += count;
    endtask

    // Sender: offer items from the pending queue, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_window(sample_t'(s_axis_tdata));
                offer_held = 1'b0;
            end
            if (!offer_held)
            begin
                if (pending_samples.size() != 0 &&
                    (steady_flow || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    s_axis_tdata  <= pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    offer_held = 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: check results, stall at random or hold off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (hold_request && hold_left == 0)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("sliding_window_min_avg_max test failed");
                $finish;
            end
        end
    end

    initial
    begin
        len_t pick;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset length of eight; the first sample fills the whole ring
        pending_samples.push_back(SAMPLE_POS_MAX);
        pending_samples.push_back(SAMPLE_NEG_MAX);
        pending_samples.push_back(sample_t'(0));
        pending_samples.push_back(sample_t'(-1));
        pending_samples.push_back(sample_t'(1));
        pending_samples.push_back(sample_t'(16'h5555));
        pending_samples.push_back(sample_t'(16'haaaa));

        // Shortest real window; negative odd sum truncates toward zero
        reconfigure_window(LEN_MIN);
        pending_samples.push_back(sample_t'(-1));
        pending_samples.push_back(sample_t'(-2));
        pending_samples.push_back(sample_t'(3));

        // Window of one and of zero give the short status
        reconfigure_window(len_t'(1));
        pending_samples.push_back(sample_t'(100));
        pending_samples.push_back(SAMPLE_NEG_MAX);
        reconfigure_window(len_t'(0));
        pending_samples.push_back(SAMPLE_POS_MAX);

        // Above the limit saturates, then the full window over old entries
        reconfigure_window(len_t'(127));
        pending_samples.push_back(SAMPLE_POS_MAX);
        pending_samples.push_back(SAMPLE_NEG_MAX);
        reconfigure_window(LEN_LIMIT);
        pending_samples.push_back(SAMPLE_POS_MAX);
        pending_samples.push_back(SAMPLE_POS_MAX);
        pending_samples.push_back(SAMPLE_NEG_MAX);
        pending_samples.push_back(sample_t'(0));

        // Long stretch with no idling on either side
        reconfigure_window(len_t'(10));
        steady_flow = 1'b1;
        queue_random(60);
        wait_drained();
        steady_flow = 1'b0;

        // Hold off the receiver so the block fills and stalls its input
        reconfigure_window(LEN_LIMIT);
        hold_request = 1'b1;
        queue_random(20);

        // Random lengths, mostly short windows
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(9))
                0: pick = len_t'($urandom_range(1));
                1: pick = LEN_LIMIT;
                2: pick = len_t'($urandom_range(127, 65));
                3: pick = len_t'($urandom_range(63, 17));
                default: pick = len_t'($urandom_range(16, 2));
            endcase
            reconfigure_window(pick);
            queue_random($urandom_range(40, 15));
        end

        wait_drained();
        $display("Checked %0d windows (%0d short) across %0d length writes,",
                 windows_checked, short_windows, lengths_written);
        $display("including saturated lengths, random stalls and a %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("sliding_window_min_avg_max test passed");
        else
            $display("sliding_window_min_avg_max test failed");
        $finish;
    end

endmodule

// File: sim.f
sv/swmm_pkg.sv
sv/swmm_ram.sv
sv/swmm_div.sv
sv/sliding_window_min_avg_max.sv
test/tb_top.sv
